/* sv/stc_pkg.sv */
// Package for the square tone channel with sweep: transfer types, event and
// register codes, the duty pattern table and the sweep frequency calculation.
// No dependencies.
package stc_pkg;

  typedef enum logic [2:0] {
    MODE_WRITE    = 3'd0,
    MODE_TICK     = 3'd1,
    MODE_LENGTH   = 3'd2,
    MODE_SWEEP    = 3'd3,
    MODE_ENVELOPE = 3'd4,
    MODE_POWER_ON = 3'd5
  } mode_e;

  typedef enum logic [2:0] {
    REG_SWEEP     = 3'd0,
    REG_DUTY_LEN  = 3'd1,
    REG_ENVELOPE  = 3'd2,
    REG_PERIOD_LO = 3'd3,
    REG_PERIOD_HI = 3'd4
  } reg_e;

  typedef struct packed {
    logic [2:0] mode;
    logic [2:0] reg_index;
    logic [7:0] write_data;
  } in_item_t;

  typedef struct packed {
    logic [3:0] level;
    logic       channel_on;
    logic       dac_on;
  } out_item_t;

  localparam logic [11:0] TimerBase  = 12'd2048;
  localparam logic [6:0]  LengthFull = 7'd64;

  // One row per duty setting, bit n is the output of sequencer step n.
  localparam logic [3:0][7:0] DutyTable = '{
    8'b0111_1110,
    8'b1110_0001,
    8'b1000_0001,
    8'b1000_0000
  };

  // Next sweep frequency; bit 11 set means the result has overflowed.
  function automatic logic [11:0] sweep_calc(input logic [10:0] freq,
                                             input logic [2:0]  shift,
                                             input logic        down);
    logic [11:0] delta;
    delta = {1'b0, freq >> shift};
    if (down) begin
      sweep_calc = {1'b0, freq} - delta;
    end else begin
      sweep_calc = {1'b0, freq} + delta;
    end
  endfunction

endpackage

/* sv/square_tone_channel_with_sweep_unit.sv */
// Top level of the square tone channel with sweep: event decode, channel state
// and a two-entry output buffer. Depends on stc_pkg.
//
// Each transfer on the input channel carries one event: a write to one of the
// five channel registers, a timer tick, a length clock, a sweep clock followed
// by a length clock, an envelope clock, or power-on. The event is applied to
// the channel state in the cycle in which it is accepted, and one result
// transfer follows, carrying the output level, the channel enable flag and the
// DAC power flag as they stand after the event. A new event may be accepted
// in every cycle in which the input is not stalled, so the sustained rate is
// one event per cycle while results are taken. All of the update work sits
// in a single combinational stage between the state registers and the result
// register; the longest path there is the sweep update, which runs two
// 11-bit shift-and-add steps in series. The result register is backed by a
// skid register, so an event is still taken while one finished result waits
// for the downstream side; input stall is raised only once both hold results.
// The timer advances on every second tick, and the duty sequencer moves on
// one step each time the timer down-counter expires. A sweep period of zero
// disables the sweep clock, and a trigger does not reload the timer counter.
module square_tone_channel_with_sweep_unit
  import stc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  // Channel state.
  logic        tick_q,        tick_d;
  logic [11:0] timer_cnt_q,   timer_cnt_d;
  logic [11:0] timer_rld_q,   timer_rld_d;
  logic [1:0]  duty_sel_q,    duty_sel_d;
  logic [2:0]  duty_step_q,   duty_step_d;
  logic [6:0]  len_cnt_q,     len_cnt_d;
  logic        len_en_q,      len_en_d;
  logic [3:0]  env_level_q,   env_level_d;
  logic [2:0]  env_cnt_q,     env_cnt_d;
  logic [2:0]  env_live_q,    env_live_d;
  logic        env_inc_q,     env_inc_d;
  logic [3:0]  start_vol_q,   start_vol_d;
  logic [2:0]  env_saved_q,   env_saved_d;
  logic [2:0]  swp_period_q,  swp_period_d;
  logic [2:0]  swp_shift_q,   swp_shift_d;
  logic        swp_down_q,    swp_down_d;
  logic [2:0]  swp_cnt_q,     swp_cnt_d;
  logic [10:0] swp_shadow_q,  swp_shadow_d;
  logic        swp_active_q,  swp_active_d;
  logic [10:0] period_q,      period_d;
  logic        chan_en_q,     chan_en_d;
  logic        dac_q,         dac_d;

  // Output buffer.
  logic        out_valid_q;
  out_item_t   out_q;
  logic        skid_valid_q;
  out_item_t   skid_q;

  logic        in_accept;
  logic        out_free;
  out_item_t   result;

  // The skid register is the only thing that can block the input side.
  assign in_stall_o = skid_valid_q;
  assign in_accept  = in_valid_i && !skid_valid_q;
  assign out_free   = !out_valid_q || !out_stall_i;

  // Event decode and state update. Each branch follows the order in which the
  // channel applies its sub-steps, so later steps see the earlier results.
  always_comb begin
    logic [11:0] f;
    logic [11:0] f2;
    logic [7:0]  d;

    tick_d       = tick_q;
    timer_cnt_d  = timer_cnt_q;
    timer_rld_d  = timer_rld_q;
    duty_sel_d   = duty_sel_q;
    duty_step_d  = duty_step_q;
    len_cnt_d    = len_cnt_q;
    len_en_d     = len_en_q;
    env_level_d  = env_level_q;
    env_cnt_d    = env_cnt_q;
    env_live_d   = env_live_q;
    env_inc_d    = env_inc_q;
    start_vol_d  = start_vol_q;
    env_saved_d  = env_saved_q;
    swp_period_d = swp_period_q;
    swp_shift_d  = swp_shift_q;
    swp_down_d   = swp_down_q;
    swp_cnt_d    = swp_cnt_q;
    swp_shadow_d = swp_shadow_q;
    swp_active_d = swp_active_q;
    period_d     = period_q;
    chan_en_d    = chan_en_q;
    dac_d        = dac_q;
    f            = '0;
    f2           = '0;
    d            = in_data_i.write_data;

    unique case (in_data_i.mode) inside
      MODE_WRITE: begin
        unique case (in_data_i.reg_index)
          REG_SWEEP: begin
            swp_period_d = d[6:4];
            swp_down_d   = d[3];
            swp_shift_d  = d[2:0];
          end
          REG_DUTY_LEN: begin
            duty_sel_d = d[7:6];
            len_cnt_d  = LengthFull - {1'b0, d[5:0]};
          end
          REG_ENVELOPE: begin
            start_vol_d = d[7:4];
            env_level_d = d[7:4];
            env_inc_d   = d[3];
            env_saved_d = d[2:0];
            env_live_d  = d[2:0];
            env_cnt_d   = d[2:0];
            dac_d       = (d[7:3] != 5'd0);
            if (!dac_d) begin
              chan_en_d = 1'b0;
            end
          end
          REG_PERIOD_LO: begin
            period_d    = {period_q[10:8], d};
            timer_rld_d = TimerBase - {1'b0, period_d};
          end
          REG_PERIOD_HI: begin
            period_d    = {d[2:0], period_q[7:0]};
            timer_rld_d = TimerBase - {1'b0, period_d};
            len_en_d    = d[6];
            if (d[7]) begin
              // Trigger: restart length, envelope and sweep from the registers.
              if (len_cnt_d == 7'd0) begin
                len_cnt_d = LengthFull;
              end
              swp_shadow_d = period_d;
              swp_cnt_d    = swp_period_q;
              env_live_d   = env_saved_q;
              env_cnt_d    = env_saved_q;
              env_level_d  = start_vol_q;
              chan_en_d    = dac_q;
              if ((swp_period_q != 3'd0) || (swp_shift_q != 3'd0)) begin
                swp_active_d = 1'b1;
                f = sweep_calc(period_d, swp_shift_q, swp_down_q);
                if (f[11]) begin
                  chan_en_d    = 1'b0;
                  swp_active_d = 1'b0;
                end
              end else begin
                swp_active_d = 1'b0;
              end
            end
          end
          default: begin
          end
        endcase
      end
      MODE_TICK: begin
        tick_d = ~tick_q;
        if (!tick_d) begin
          timer_cnt_d = timer_cnt_q - 12'd1;
          if (timer_cnt_q == 12'd1) begin
            timer_cnt_d = timer_rld_q;
            duty_step_d = duty_step_q + 3'd1;
          end
        end
      end
      MODE_LENGTH, MODE_SWEEP: begin
        if ((in_data_i.mode == MODE_SWEEP) && swp_active_q && (swp_period_q != 3'd0)) begin
          swp_cnt_d = swp_cnt_q - 3'd1;
          if (swp_cnt_q == 3'd1) begin
            swp_cnt_d = swp_period_q;
            f = sweep_calc(swp_shadow_q, swp_shift_q, swp_down_q);
            if (f[11]) begin
              chan_en_d    = 1'b0;
              swp_active_d = 1'b0;
            end else if (swp_shift_q != 3'd0) begin
              swp_shadow_d = f[10:0];
              period_d     = f[10:0];
              timer_rld_d  = TimerBase - f;
              // The new frequency is checked once more for overflow.
              f2 = sweep_calc(f[10:0], swp_shift_q, swp_down_q);
              if (f2[11]) begin
                chan_en_d    = 1'b0;
                swp_active_d = 1'b0;
              end
            end
          end
        end
        if (len_en_q && (len_cnt_q != 7'd0)) begin
          len_cnt_d = len_cnt_q - 7'd1;
          if (len_cnt_d == 7'd0) begin
            len_en_d  = 1'b0;
            chan_en_d = 1'b0;
          end
        end
      end
      MODE_ENVELOPE: begin
        if (env_live_q != 3'd0) begin
          env_cnt_d = env_cnt_q - 3'd1;
          if (env_cnt_q == 3'd1) begin
            env_cnt_d = env_live_q;
            if (env_inc_q) begin
              if (env_level_q != 4'd15) begin
                env_level_d = env_level_q + 4'd1;
              end
            end else if (env_level_q != 4'd0) begin
              env_level_d = env_level_q - 4'd1;
            end
          end
        end
      end
      MODE_POWER_ON: begin
        duty_step_d = '0;
      end
      default: begin
      end
    endcase
  end

  // The result reflects the state after the event.
  always_comb begin
    result.channel_on = chan_en_d;
    result.dac_on     = dac_d;
    result.level      = (chan_en_d && DutyTable[duty_sel_d][duty_step_d]) ?
                        env_level_d : 4'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q       <= 1'b0;
      timer_cnt_q  <= 12'd1;
      timer_rld_q  <= TimerBase;
      duty_sel_q   <= '0;
      duty_step_q  <= '0;
      len_cnt_q    <= LengthFull;
      len_en_q     <= 1'b0;
      env_level_q  <= '0;
      env_cnt_q    <= '0;
      env_live_q   <= '0;
      env_inc_q    <= 1'b0;
      start_vol_q  <= '0;
      env_saved_q  <= '0;
      swp_period_q <= '0;
      swp_shift_q  <= '0;
      swp_down_q   <= 1'b0;
      swp_cnt_q    <= '0;
      swp_shadow_q <= '0;
      swp_active_q <= 1'b0;
      period_q     <= '0;
      chan_en_q    <= 1'b0;
      dac_q        <= 1'b0;
    end else if (in_accept) begin
      tick_q       <= tick_d;
      timer_cnt_q  <= timer_cnt_d;
      timer_rld_q  <= timer_rld_d;
      duty_sel_q   <= duty_sel_d;
      duty_step_q  <= duty_step_d;
      len_cnt_q    <= len_cnt_d;
      len_en_q     <= len_en_d;
      env_level_q  <= env_level_d;
      env_cnt_q    <= env_cnt_d;
      env_live_q   <= env_live_d;
      env_inc_q    <= env_inc_d;
      start_vol_q  <= start_vol_d;
      env_saved_q  <= env_saved_d;
      swp_period_q <= swp_period_d;
      swp_shift_q  <= swp_shift_d;
      swp_down_q   <= swp_down_d;
      swp_cnt_q    <= swp_cnt_d;
      swp_shadow_q <= swp_shadow_d;
      swp_active_q <= swp_active_d;
      period_q     <= period_d;
      chan_en_q    <= chan_en_d;
      dac_q        <= dac_d;
    end
  end

  // Output buffer control. The skid register only fills while the result
  // register is full and stalled, and drains first once it frees up.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q  <= skid_valid_q || in_accept;
      skid_valid_q <= 1'b0;
    end else if (in_accept) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_q <= skid_valid_q ? skid_q : result;
    end else if (in_accept) begin
      skid_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // The skid register never holds a result while the result register is empty.
  a_skid_needs_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid register full while result register empty");

  // An event accepted while the result register is blocked lands in the skid.
  a_stalled_accept_to_skid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && out_valid_q && out_stall_i) |=> skid_valid_q)
    else $error("accepted event lost while output stalled");

  // The channel can only be enabled while the DAC is powered.
  a_chan_needs_dac : assert property (@(posedge clk_i) disable iff (!rst_ni)
    chan_en_q |-> dac_q)
    else $error("channel enabled with DAC off");

  // A non-zero level is only ever reported for an enabled channel.
  a_level_needs_chan : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.level != 4'd0)) |-> out_data_o.channel_on)
    else $error("level reported for a disabled channel");

endmodule

/* test/square_tone_channel_with_sweep_unit_tb.sv */
// Self-checking testbench for the square tone channel with sweep unit.
// It holds a scoreboard class that predicts each result and drives the block with plain tasks.
// It depends on stc_pkg and on square_tone_channel_with_sweep_unit.
module square_tone_channel_with_sweep_unit_tb
  import stc_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  // The two mode codes that the package leaves unnamed. The block must treat them as no-ops.
  localparam logic [2:0] ModeUnused6 = 3'd6;
  localparam logic [2:0] ModeUnused7 = 3'd7;
  // The lowest and the highest register index that the block has no register behind.
  localparam logic [2:0] RegUnused5  = 3'd5;
  localparam logic [2:0] RegUnused7  = 3'd7;

  localparam int unsigned PlanLength = 1530;
  localparam int unsigned HoldCycles = 48;
  localparam int unsigned QuietLimit = 1000;
  localparam int unsigned DrainCycles = 8;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_style_e;

  // The tracker keeps its own copy of the channel state. Each accepted event moves that
  // state on, and the result that the event should produce is queued. Result transfers
  // from the block are then checked against that queue in order.
  class tone_channel_tracker;
    logic        div_phase;
    logic [11:0] tmr_count, tmr_reload;
    logic [1:0]  duty_sel;
    logic [2:0]  duty_pos;
    logic [6:0]  len_count;
    logic        len_en;
    logic [3:0]  vol, vol_init;
    logic [2:0]  env_tick, env_per, env_per_init;
    logic        env_up;
    logic [2:0]  swp_per, swp_shift, swp_tick;
    logic        swp_neg, swp_on;
    logic [10:0] swp_freq, freq;
    logic        ch_on, dac_on;

    out_item_t   pending_outputs[$];
    int unsigned checked, mismatches, triggers, duty_steps, len_expiries, overflows;

    function new();
      div_phase = 1'b0;  tmr_count = 12'd1;  tmr_reload = TimerBase;
      duty_sel = 2'd0;   duty_pos = 3'd0;    len_count = LengthFull;  len_en = 1'b0;
      vol = 4'd0;        vol_init = 4'd0;    env_tick = 3'd0;  env_per = 3'd0;
      env_per_init = 3'd0;  env_up = 1'b0;
      swp_per = 3'd0;    swp_shift = 3'd0;   swp_tick = 3'd0;  swp_neg = 1'b0;
      swp_on = 1'b0;     swp_freq = 11'd0;   freq = 11'd0;
      ch_on = 1'b0;      dac_on = 1'b0;
      checked = 0;  mismatches = 0;  triggers = 0;  duty_steps = 0;
      len_expiries = 0;  overflows = 0;
    endfunction

    function bit duty_high(logic [1:0] sel, logic [2:0] pos);
      logic [7:0] wave;
      case (sel)
        2'd0:    wave = 8'b1000_0000;
        2'd1:    wave = 8'b1000_0001;
        2'd2:    wave = 8'b1110_0001;
        default: wave = 8'b0111_1110;
      endcase
      return wave[pos];
    endfunction

    // The next sweep frequency. Any overflow above the 11-bit range silences the channel.
    function logic [11:0] sweep_target();
      logic [11:0] delta, target;
      delta = {1'b0, swp_freq >> swp_shift};
      target = swp_neg ? {1'b0, swp_freq} - delta : {1'b0, swp_freq} + delta;
      if (target > 12'd2047) begin
        ch_on = 1'b0;
        swp_on = 1'b0;
        overflows++;
      end
      return target;
    endfunction

    function void fire_trigger();
      triggers++;
      if (len_count == 7'd0) len_count = LengthFull;
      tmr_reload = TimerBase - {1'b0, freq};
      swp_freq = freq;
      swp_tick = swp_per;
      env_per = env_per_init;
      env_tick = env_per_init;
      vol = vol_init;
      ch_on = dac_on;
      if (swp_per != 3'd0 || swp_shift != 3'd0) begin
        swp_on = 1'b1;
        void'(sweep_target());
      end else begin
        swp_on = 1'b0;
      end
    endfunction

    function void write_reg(logic [2:0] idx, logic [7:0] d);
      case (idx)
        REG_SWEEP: begin
          swp_per = d[6:4];
          swp_neg = d[3];
          swp_shift = d[2:0];
        end
        REG_DUTY_LEN: begin
          duty_sel = d[7:6];
          len_count = LengthFull - {1'b0, d[5:0]};
        end
        REG_ENVELOPE: begin
          vol_init = d[7:4];
          vol = d[7:4];
          env_up = d[3];
          env_per_init = d[2:0];
          env_per = d[2:0];
          env_tick = d[2:0];
          dac_on = (d[7:3] != 5'd0);
          if (!dac_on) ch_on = 1'b0;
        end
        REG_PERIOD_LO: begin
          freq[7:0] = d;
          tmr_reload = TimerBase - {1'b0, freq};
        end
        REG_PERIOD_HI: begin
          freq[10:8] = d[2:0];
          tmr_reload = TimerBase - {1'b0, freq};
          len_en = d[6];
          if (d[7]) fire_trigger();
        end
        default: ;
      endcase
    endfunction

    function void advance_length();
      if (len_en && len_count != 7'd0) begin
        len_count = len_count - 7'd1;
        if (len_count == 7'd0) begin
          len_en = 1'b0;
          ch_on = 1'b0;
          len_expiries++;
        end
      end
    endfunction

    function void advance_sweep();
      logic [2:0]  prev;
      logic [11:0] target;
      if (!swp_on || swp_per == 3'd0) return;
      prev = swp_tick;
      swp_tick = swp_tick - 3'd1;
      if (swp_tick == 3'd0 && prev != 3'd0) begin
        swp_tick = swp_per;
        target = sweep_target();
        if (target < 12'd2048 && swp_shift != 3'd0) begin
          swp_freq = target[10:0];
          freq = target[10:0];
          tmr_reload = TimerBase - target;
          void'(sweep_target());
        end
      end
    endfunction

    function void advance_envelope();
      logic [2:0] prev;
      if (env_per == 3'd0) return;
      prev = env_tick;
      env_tick = env_tick - 3'd1;
      if (prev != 3'd0 && env_tick == 3'd0) begin
        env_tick = env_per;
        if (env_up) begin
          if (vol < 4'd15) vol = vol + 4'd1;
        end else if (vol > 4'd0) begin
          vol = vol - 4'd1;
        end
      end
    endfunction

    // The timer moves only on every second tick. The duty sequencer steps on each expiry.
    function void tick_timer();
      logic [11:0] prev;
      div_phase = ~div_phase;
      if (div_phase) return;
      prev = tmr_count;
      tmr_count = tmr_count - 12'd1;
      if (prev != 12'd0 && tmr_count == 12'd0) begin
        tmr_count = tmr_reload;
        duty_pos = duty_pos + 3'd1;
        duty_steps++;
      end
    endfunction

    function void note_event(in_item_t ev);
      out_item_t res;
      case (ev.mode)
        MODE_WRITE:    write_reg(ev.reg_index, ev.write_data);
        MODE_TICK:     tick_timer();
        MODE_LENGTH:   advance_length();
        MODE_SWEEP: begin
          advance_sweep();
          advance_length();
        end
        MODE_ENVELOPE: advance_envelope();
        MODE_POWER_ON: duty_pos = 3'd0;
        default: ;
      endcase
      res.level = (ch_on && duty_high(duty_sel, duty_pos)) ? vol : 4'd0;
      res.channel_on = ch_on;
      res.dac_on = dac_on;
      pending_outputs.push_back(res);
    endfunction

    function void check_output(out_item_t got);
      out_item_t want;
      if (pending_outputs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result transfer with nothing outstanding: level %0d on %0b dac %0b",
                   $time, got.level, got.channel_on, got.dac_on);
        return;
      end
      want = pending_outputs.pop_front();
      checked++;
      if (got.level !== want.level || got.channel_on !== want.channel_on ||
          got.dac_on !== want.dac_on) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result %0d: level %0d/%0d on %0b/%0b dac %0b/%0b (expected/actual)",
                   $time, checked, want.level, got.level, want.channel_on, got.channel_on,
                   want.dac_on, got.dac_on);
      end
    endfunction
  endclass

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_item_t  in_data_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_item_t out_data_o;

  tone_channel_tracker tracker = new();
  in_item_t            event_plan[$];

  square_tone_channel_with_sweep_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Every input is given a known value at time zero, before the first edge.
  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    out_stall_i = 1'b0;
  end

  task automatic plan_event(input logic [2:0] mode, input logic [2:0] idx,
                            input logic [7:0] d);
    in_item_t ev;
    ev.mode = mode;
    ev.reg_index = idx;
    ev.write_data = d;
    event_plan.push_back(ev);
  endtask

  task automatic plan_write(input logic [2:0] idx, input logic [7:0] d);
    plan_event(MODE_WRITE, idx, d);
  endtask

  // For events other than writes, the register index and the data byte are ignored.
  // They are filled with random values so that those bits still toggle.
  task automatic plan_clock(input logic [2:0] mode);
    plan_event(mode, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
  endtask

  // Results are checked at each rising edge at which a result transfer completes. Stall and
  // valid are sampled before the values for that edge are assigned.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) tracker.check_output(out_data_o);
  end

  // The receiver changes its stall style after each random span. The styles are no stall, light
  // random stall, heavy random stall and a fixed three-in-four pattern. Twice in the run, once
  // 500 and then 1000 results have been checked, it holds off completely for a long stretch.
  // The sender keeps offering transfers during that stretch, so the result buffer fills and the
  // block has to stall its input.
  initial begin : receiver
    stall_style_e style;
    int           span;
    int           holds;
    style = STALL_NONE;
    span = 0;
    holds = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (holds < 2 && tracker.checked >= (holds + 1) * 500) begin
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        holds++;
      end else begin
        if (span == 0) begin
          style = stall_style_e'($urandom_range(0, 3));
          span = $urandom_range(30, 150);
        end
        span--;
        case (style)
          STALL_NONE:  out_stall_i <= 1'b0;
          STALL_LIGHT: out_stall_i <= ($urandom_range(0, 3) == 0);
          STALL_HEAVY: out_stall_i <= ($urandom_range(0, 9) < 6);
          default:     out_stall_i <= (span % 4 != 0);
        endcase
      end
    end
  end

  // The watchdog ends the run if neither channel completes a transfer for too long. The
  // longest gap that a correct run can show is the receiver's hold.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no transfer for %0d cycles", $time, QuietLimit);
    $display("square_tone_channel_with_sweep_unit_tb failed");
    $finish;
  end

  initial begin : stimulus
    int unsigned plan_pos;
    int          burst;
    int          gap;
    int          n;
    int          p;
    logic [7:0]  d;

    // Directed opening. It starts with the unused modes and register indexes on the reset state.
    plan_clock(ModeUnused6);
    plan_clock(ModeUnused7);
    plan_write(RegUnused5, 8'hFF);
    plan_write(RegUnused7, 8'hFF);
    // The highest period gives a timer reload of one. Two ticks then reach the first expiry.
    plan_write(REG_PERIOD_LO, 8'hFF);
    plan_write(REG_PERIOD_HI, 8'h07);
    plan_clock(MODE_TICK);
    plan_clock(MODE_TICK);
    // Full volume with a frozen envelope, the widest duty and the shortest length.
    // A trigger follows, with the length counter enabled.
    plan_write(REG_ENVELOPE, 8'hF0);
    plan_write(REG_DUTY_LEN, 8'hFF);
    plan_write(REG_SWEEP, 8'h00);
    plan_write(REG_PERIOD_HI, 8'hC7);
    plan_clock(MODE_TICK);
    plan_clock(MODE_TICK);
    plan_clock(MODE_ENVELOPE);
    plan_clock(MODE_POWER_ON);
    plan_clock(MODE_LENGTH);
    // The DAC is kept on by the direction bit alone, then it is switched off and on again.
    plan_write(REG_ENVELOPE, 8'h0F);
    plan_write(REG_ENVELOPE, 8'h07);
    plan_write(REG_ENVELOPE, 8'h1A);
    // An upward sweep overflows at the trigger check.
    plan_write(REG_SWEEP, 8'h71);
    plan_write(REG_PERIOD_HI, 8'h87);
    // A downward sweep with the largest shift is updated on its first clock. A zero shift
    // then skips the update.
    plan_write(REG_SWEEP, 8'h1F);
    plan_write(REG_PERIOD_HI, 8'h87);
    plan_clock(MODE_SWEEP);
    plan_write(REG_SWEEP, 8'h10);
    plan_clock(MODE_SWEEP);
    plan_clock(MODE_ENVELOPE);
    plan_clock(MODE_ENVELOPE);
    // A sweep period of zero leaves the sweep clock with nothing to do. The length becomes 64.
    plan_write(REG_DUTY_LEN, 8'h00);
    plan_write(REG_SWEEP, 8'h00);
    plan_clock(MODE_SWEEP);

    // The random part is made of notes. Each note is a register setup ending in a trigger,
    // followed by a run of clock events. About one write in eight is dropped, and some
    // triggers are left out, so that broken setups also appear. Periods lean towards the top
    // of the range, so that the timer reload stays short and the duty sequencer keeps moving.
    while (event_plan.size() < PlanLength) begin
      d = 8'($urandom_range(0, 255));
      p = $urandom_range(0, 3);
      if (p == 0) d = 8'h00;
      else if (p == 2) d = {1'b0, 3'($urandom_range(1, 3)), 1'b1, 3'($urandom_range(1, 7))};
      if ($urandom_range(0, 7) != 0) plan_write(REG_SWEEP, d);

      d = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 3) == 0) d[5:0] = 6'd60 + 6'($urandom_range(0, 3));
      if ($urandom_range(0, 7) != 0) plan_write(REG_DUTY_LEN, d);

      d = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 3) != 0) begin
        d[7:4] = 4'($urandom_range(1, 15));
        d[2:0] = 3'($urandom_range(1, 3));
      end
      if ($urandom_range(0, 7) != 0) plan_write(REG_ENVELOPE, d);

      d = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 3) != 0) d[7:5] = 3'b111;
      if ($urandom_range(0, 7) != 0) plan_write(REG_PERIOD_LO, d);

      d = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 7) != 0) d[2:0] = 3'd7;
      d[7] = ($urandom_range(0, 7) != 0);
      plan_write(REG_PERIOD_HI, d);

      n = $urandom_range(8, 40);
      repeat (n) begin
        p = $urandom_range(0, 99);
        if (p < 60)      plan_clock(MODE_TICK);
        else if (p < 68) plan_clock(MODE_LENGTH);
        else if (p < 76) plan_clock(MODE_SWEEP);
        else if (p < 86) plan_clock(MODE_ENVELOPE);
        else if (p < 89) plan_clock(MODE_POWER_ON);
        else if (p < 93) plan_clock(($urandom_range(0, 1) == 0) ? ModeUnused6 : ModeUnused7);
        else plan_write(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
      end
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // The sender works in bursts of random length. Between bursts it leaves gaps of random
    // length. About a quarter of the bursts run straight on into the next one with no gap.
    // The payload holds steady while the block stalls. Each event reaches the tracker at the
    // edge at which its transfer completes.
    plan_pos = 0;
    while (plan_pos < event_plan.size()) begin
      burst = $urandom_range(1, 24);
      while (burst > 0 && plan_pos < event_plan.size()) begin
        in_valid_i <= 1'b1;
        in_data_i <= event_plan[plan_pos];
        @(posedge clk_i);
        while (in_stall_o) @(posedge clk_i);
        tracker.note_event(event_plan[plan_pos]);
        plan_pos++;
        burst--;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b0;

    // Drain the outstanding results. The wait that follows lets any spurious extra
    // transfer still show up.
    while (tracker.pending_outputs.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    tracker.mismatches += tracker.pending_outputs.size();

    $display("Checked %0d results over %0d events: %0d triggers, %0d duty steps,",
             tracker.checked, event_plan.size(), tracker.triggers, tracker.duty_steps);
    $display("%0d length expiries, %0d sweep overflows, %0d mismatches.",
             tracker.len_expiries, tracker.overflows, tracker.mismatches);
    if (tracker.mismatches == 0) begin
      $display("square_tone_channel_with_sweep_unit_tb passed");
    end else begin
      $display("square_tone_channel_with_sweep_unit_tb failed");
    end
    $finish;
  end

endmodule

/* files.f */
sv/stc_pkg.sv
sv/square_tone_channel_with_sweep_unit.sv
test/square_tone_channel_with_sweep_unit_tb.sv
